### rtl/smvs_pkg.sv
// ----------------------------------------------------------------------------
// smvs_pkg
// Shared constants, codes and types for the stack machine with variable store.
// ----------------------------------------------------------------------------
package smvs_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VAR_COUNT   = 64;

  localparam int SP_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int VI_W    = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = DATA_W + 1;  // bit DATA_W is the name tag
  localparam int NAME_W  = 6;

  // instruction codes
  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_SUB    = 3'd2;
  localparam logic [2:0] MODE_MULT   = 3'd3;
  localparam logic [2:0] MODE_ASSIGN = 3'd4;
  localparam logic [2:0] MODE_PRINT  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_PRINTED     = 3'd1;
  localparam logic [2:0] ST_OP_ERROR    = 3'd2;
  localparam logic [2:0] ST_PRINT_ERROR = 3'd3;
  localparam logic [2:0] ST_IGNORED     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC
  } smvs_state_t;

endpackage

### rtl/smvs_ram.sv
// ----------------------------------------------------------------------------
// smvs_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module smvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/stack_machine_with_variable_store_top.sv
// ----------------------------------------------------------------------------
// stack_machine_with_variable_store_top
// Stack-machine interpreter: tagged operand stack and a variable store, both
// held in synchronous RAM.
// ----------------------------------------------------------------------------
// One instruction per input transaction, one result transaction per
// instruction. PUSH, a bad command, an instruction that finds too few stack
// entries and any instruction after a halt finish in S_IDLE. Otherwise
// PRINT, ADD, SUB, MULT and ASSIGN go through a stack RAM read, a variable
// RAM read of the named operands, then execute and write back. The next
// instruction is taken in the cycle after the previous one finishes,
// provided the result register is free or being drained. No clearing pass
// after reset: variable defined bits live in flops and stack entries are
// only read below the stack count. Once an error halts the block, every
// later instruction returns status ignored until reset.
// ----------------------------------------------------------------------------
module stack_machine_with_variable_store_top
  import smvs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_mode,
  input  logic                     in_operand_is_name,
  input  logic signed [DATA_W-1:0] in_operand_value,
  input  logic [NAME_W-1:0]        in_operand_name,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic signed [DATA_W-1:0] out_print_value,
  output logic                     out_halted
);

  smvs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               stopped_r, stopped_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [ENTRY_W-1:0] top_r, top_nxt;
  logic [ENTRY_W-1:0] next_r, next_nxt;
  logic [VAR_COUNT-1:0] vdef_r, vdef_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_halted_r, out_halted_nxt;

  logic out_free, in_accept;

  // stack RAM ports
  logic               stk_we, stk_re;
  logic [SP_W-1:0]    stk_waddr, stk_raddr_a, stk_raddr_b;
  logic [ENTRY_W-1:0] stk_wdata, stk_rdata_a, stk_rdata_b;

  // variable RAM ports
  logic              var_we, var_re;
  logic [VI_W-1:0]   var_waddr, var_raddr_a, var_raddr_b;
  logic [DATA_W-1:0] var_wdata, var_rdata_a, var_rdata_b;

  // operand resolution in S_EXEC
  logic              ok_a, ok_b, top_in_range, next_in_range;
  logic [VI_W-1:0]   top_idx, next_idx;
  logic [DATA_W-1:0] val_a, val_b, arith_res;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);

  assign top_idx       = top_r[VI_W-1:0];
  assign next_idx      = next_r[VI_W-1:0];
  assign top_in_range  = top_r[DATA_W-1:0] < DATA_W'(VAR_COUNT);
  assign next_in_range = next_r[DATA_W-1:0] < DATA_W'(VAR_COUNT);

  assign ok_a  = !top_r[DATA_W] || (top_in_range && vdef_r[top_idx]);
  assign ok_b  = !next_r[DATA_W] || (next_in_range && vdef_r[next_idx]);
  assign val_a = top_r[DATA_W] ? var_rdata_a : top_r[DATA_W-1:0];
  assign val_b = next_r[DATA_W] ? var_rdata_b : next_r[DATA_W-1:0];

  always_comb begin
    case (op_r)
      MODE_ADD: arith_res = val_b + val_a;
      MODE_SUB: arith_res = val_b - val_a;
      default:  arith_res = val_b * val_a;
    endcase
  end

  smvs_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .re_a    (stk_re),
    .raddr_a (stk_raddr_a),
    .rdata_a (stk_rdata_a),
    .re_b    (stk_re),
    .raddr_b (stk_raddr_b),
    .rdata_b (stk_rdata_b)
  );

  smvs_ram #(.WIDTH(DATA_W), .DEPTH(VAR_COUNT)) u_var_ram (
    .clk     (clk),
    .we      (var_we),
    .waddr   (var_waddr),
    .wdata   (var_wdata),
    .re_a    (var_re),
    .raddr_a (var_raddr_a),
    .rdata_a (var_rdata_a),
    .re_b    (var_re),
    .raddr_b (var_raddr_b),
    .rdata_b (var_rdata_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && !stopped_r) begin
          unique case (in_mode)
            MODE_ADD, MODE_SUB, MODE_MULT, MODE_ASSIGN: begin
              if (cnt_r >= CNT_W'(2)) state_nxt = S_LOAD;
            end
            MODE_PRINT: begin
              if (cnt_r != '0) state_nxt = S_LOAD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt        = cnt_r;
    stopped_nxt    = stopped_r;
    op_nxt         = op_r;
    top_nxt        = top_r;
    next_nxt       = next_r;
    vdef_nxt       = vdef_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_halted_nxt = out_halted_r;

    stk_we      = 1'b0;
    stk_waddr   = cnt_r[SP_W-1:0];
    stk_wdata   = {1'b0, arith_res};
    stk_re      = 1'b0;
    stk_raddr_a = cnt_m1[SP_W-1:0];
    stk_raddr_b = cnt_m2[SP_W-1:0];
    var_we      = 1'b0;
    var_waddr   = next_idx;
    var_wdata   = val_a;
    var_re      = 1'b0;
    var_raddr_a = stk_rdata_a[VI_W-1:0];
    var_raddr_b = stk_rdata_b[VI_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_value_nxt  = '0;
          op_nxt         = in_mode;
          if (stopped_r) begin
            out_status_nxt = ST_IGNORED;
          end else begin
            unique case (in_mode)
              MODE_PUSH: begin
                if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                  out_status_nxt = ST_OP_ERROR;
                end else if (in_operand_is_name &&
                             DATA_W'(in_operand_name) >= DATA_W'(VAR_COUNT)) begin
                  out_status_nxt = ST_OP_ERROR;
                end else begin
                  stk_we    = 1'b1;
                  stk_wdata = in_operand_is_name ?
                              {1'b1, DATA_W'(in_operand_name)} :
                              {1'b0, in_operand_value};
                  cnt_nxt   = cnt_r + CNT_W'(1);
                end
              end
              MODE_ADD, MODE_SUB, MODE_MULT, MODE_ASSIGN: begin
                if (cnt_r < CNT_W'(2)) begin
                  out_status_nxt = ST_OP_ERROR;
                end else begin
                  out_valid_nxt = 1'b0;
                  stk_re        = 1'b1;
                  cnt_nxt       = cnt_m2;
                end
              end
              MODE_PRINT: begin
                if (cnt_r == '0) begin
                  out_status_nxt = ST_OP_ERROR;
                end else begin
                  out_valid_nxt = 1'b0;
                  stk_re        = 1'b1;
                  cnt_nxt       = cnt_m1;
                end
              end
              default: out_status_nxt = ST_OP_ERROR;
            endcase
            if (out_status_nxt == ST_OP_ERROR) stopped_nxt = 1'b1;
          end
          out_halted_nxt = stopped_nxt;
        end
      end

      S_LOAD: begin
        // stack entries are back; look up any names they carry
        top_nxt  = stk_rdata_a;
        next_nxt = stk_rdata_b;
        var_re   = 1'b1;
      end

      S_EXEC: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_value_nxt  = '0;
        unique case (op_r)
          MODE_ASSIGN: begin
            // destination is checked before the source
            if (!next_r[DATA_W] || !next_in_range || !ok_a) begin
              out_status_nxt = ST_OP_ERROR;
            end else begin
              var_we             = 1'b1;
              vdef_nxt[next_idx] = 1'b1;
            end
          end
          MODE_PRINT: begin
            if (!top_r[DATA_W] || !top_in_range || !vdef_r[top_idx]) begin
              out_status_nxt = ST_PRINT_ERROR;
            end else begin
              out_status_nxt = ST_PRINTED;
              out_value_nxt  = var_rdata_a;
            end
          end
          default: begin
            if (!ok_a || !ok_b) begin
              out_status_nxt = ST_OP_ERROR;
            end else begin
              stk_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        endcase
        if (out_status_nxt == ST_OP_ERROR || out_status_nxt == ST_PRINT_ERROR) begin
          stopped_nxt = 1'b1;
        end
        out_halted_nxt = stopped_nxt;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      vdef_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stopped_r   <= stopped_nxt;
      vdef_r      <= vdef_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    top_r        <= top_nxt;
    next_r       <= next_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_halted_r <= out_halted_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_print_value = out_value_r;
  assign out_halted      = out_halted_r;

endmodule

### rtl/smvs_checker.sv
// ----------------------------------------------------------------------------
// smvs_checker
// Port-level assertions for the stack machine top level.
// ----------------------------------------------------------------------------
module smvs_checker
  import smvs_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [2:0]               out_status,
  input logic signed [DATA_W-1:0] out_print_value,
  input logic                     out_halted
);

  // a held result transaction must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_print_value) && $stable(out_halted))
    else $error("result changed while stalled");

  // no new instruction while a finished result is blocked
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result blocked");

  // errors and ignored instructions always report halted
  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OP_ERROR || out_status == ST_PRINT_ERROR ||
                  out_status == ST_IGNORED) |-> out_halted)
    else $error("error status without halted");

  // print value is zero unless a value was printed
  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PRINTED |-> out_print_value == '0)
    else $error("print value set without print");

  // once halted, success codes never appear again
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_halted |=>
      !out_valid || out_status == ST_IGNORED || out_status == ST_OP_ERROR ||
      out_status == ST_PRINT_ERROR)
    else $error("machine resumed after halt");

endmodule

bind stack_machine_with_variable_store_top smvs_checker u_smvs_checker (.*);
